// ===== rtl/lits_pkg.sv =====
// Shared types and constants for the linear index to subscripts converter.
// Used by the register bank, controller, datapath, top level and checker.
// No dependencies.
package lits_pkg;

    // Field widths and array shape.
    localparam int INDEX_WIDTH   = 32;
    localparam int DIM_WIDTH     = 16;
    localparam int NUM_DIMS      = 4;
    localparam int NDIM_WIDTH    = 3;
    localparam int DIM_SEL_WIDTH = $clog2(NUM_DIMS);
    localparam int CNT_WIDTH     = $clog2(INDEX_WIDTH);
    localparam int CFG_IDX_WIDTH = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_NUM_DIMS   = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_DIM_SIZE_0 = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_DIM_SIZE_1 = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_DIM_SIZE_2 = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_DIM_SIZE_3 = 3'd4;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_STORE,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                     load;
        logic                     step;
        logic                     store;
        logic                     finish;
        logic [DIM_SEL_WIDTH-1:0] dim_sel;
    } ctrl_cmd_t;

    // Shape summary from the register bank.
    typedef struct packed {
        logic [NDIM_WIDTH-1:0] n_used;
        logic                  zero_used;
    } cfg_status_t;

endpackage

// ===== rtl/lits_regs.sv =====
// Configuration register bank: dimension count and dimension sizes.
// Also reports the saturated dimension count and whether a used size is zero.
// Depends on lits_pkg.
module lits_regs (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    input  logic [lits_pkg::CFG_IDX_WIDTH-1:0]    cfg_index,
    input  logic [lits_pkg::DIM_WIDTH-1:0]        cfg_data,
    output logic [lits_pkg::DIM_WIDTH-1:0]        dim_size [lits_pkg::NUM_DIMS],
    output lits_pkg::cfg_status_t                 status
);

    logic [lits_pkg::NDIM_WIDTH-1:0] num_dims_reg;
    logic [lits_pkg::DIM_WIDTH-1:0]  size_reg [lits_pkg::NUM_DIMS];
    logic [lits_pkg::NDIM_WIDTH-1:0] n_used;
    logic                            zero_used;

    // Register writes; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_dims_reg <= lits_pkg::NDIM_WIDTH'(1);
            for (int k = 0; k < lits_pkg::NUM_DIMS; k++)
            begin
                size_reg[k] <= lits_pkg::DIM_WIDTH'(1);
            end
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                lits_pkg::CFG_NUM_DIMS:
                    num_dims_reg <= cfg_data[lits_pkg::NDIM_WIDTH-1:0];
                lits_pkg::CFG_DIM_SIZE_0: size_reg[0] <= cfg_data;
                lits_pkg::CFG_DIM_SIZE_1: size_reg[1] <= cfg_data;
                lits_pkg::CFG_DIM_SIZE_2: size_reg[2] <= cfg_data;
                lits_pkg::CFG_DIM_SIZE_3: size_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Saturate the count and look for a zero size among the used dimensions.
    always_comb
    begin
        if (num_dims_reg > lits_pkg::NDIM_WIDTH'(lits_pkg::NUM_DIMS))
            n_used = lits_pkg::NDIM_WIDTH'(lits_pkg::NUM_DIMS);
        else
            n_used = num_dims_reg;
        zero_used = 1'b0;
        for (int k = 0; k < lits_pkg::NUM_DIMS; k++)
        begin
            if ((lits_pkg::NDIM_WIDTH'(k) < n_used) && (size_reg[k] == '0))
                zero_used = 1'b1;
        end
    end

    assign dim_size         = size_reg;
    assign status.n_used    = n_used;
    assign status.zero_used = zero_used;

endmodule

// ===== rtl/lits_ctrl.sv =====
// Controller state machine: sequences one restoring division per used
// dimension, fastest dimension first. Depends on lits_pkg.
module lits_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  lits_pkg::cfg_status_t status,
    output logic                  busy,
    output lits_pkg::ctrl_cmd_t   cmd
);

    lits_pkg::state_t                       state_reg, state_next;
    logic [lits_pkg::CNT_WIDTH-1:0]         cnt_reg, cnt_next;
    logic [lits_pkg::DIM_SEL_WIDTH-1:0]     dim_reg, dim_next;

    // State, bit counter and dimension pointer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lits_pkg::ST_IDLE;
            cnt_reg   <= '0;
            dim_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            dim_reg   <= dim_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        dim_next   = dim_reg;
        unique case (state_reg)
            lits_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cnt_next = '0;
                    dim_next = lits_pkg::DIM_SEL_WIDTH'(status.n_used - 1'b1);
                    if ((status.n_used == '0) || status.zero_used)
                        state_next = lits_pkg::ST_DONE;
                    else
                        state_next = lits_pkg::ST_DIV;
                end
            end
            lits_pkg::ST_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == lits_pkg::CNT_WIDTH'(lits_pkg::INDEX_WIDTH - 1))
                    state_next = lits_pkg::ST_STORE;
            end
            lits_pkg::ST_STORE:
            begin
                cnt_next = '0;
                if (dim_reg == '0)
                begin
                    state_next = lits_pkg::ST_DONE;
                end
                else
                begin
                    dim_next   = dim_reg - 1'b1;
                    state_next = lits_pkg::ST_DIV;
                end
            end
            lits_pkg::ST_DONE:
                state_next = lits_pkg::ST_IDLE;
            default:
                state_next = lits_pkg::ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        busy        = (state_reg != lits_pkg::ST_IDLE);
        cmd.load    = (state_reg == lits_pkg::ST_IDLE) && start;
        cmd.step    = (state_reg == lits_pkg::ST_DIV);
        cmd.store   = (state_reg == lits_pkg::ST_STORE);
        cmd.finish  = (state_reg == lits_pkg::ST_DONE);
        cmd.dim_sel = dim_reg;
    end

endmodule

// ===== rtl/lits_dp.sv =====
// Datapath: shift-subtract divider with one quotient bit per cycle,
// subscript registers and the registered result. Depends on lits_pkg.
module lits_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  lits_pkg::ctrl_cmd_t                cmd,
    input  lits_pkg::cfg_status_t              status,
    input  logic [lits_pkg::INDEX_WIDTH-1:0]   flat_index,
    input  logic [lits_pkg::DIM_WIDTH-1:0]     dim_size [lits_pkg::NUM_DIMS],
    output logic                               done,
    output logic                               in_range,
    output logic [lits_pkg::DIM_WIDTH-1:0]     subscript [lits_pkg::NUM_DIMS]
);

    logic [lits_pkg::INDEX_WIDTH-1:0] quot_reg;
    logic [lits_pkg::DIM_WIDTH-1:0]   rem_reg;
    logic [lits_pkg::DIM_WIDTH-1:0]   sub_reg [lits_pkg::NUM_DIMS];
    logic [lits_pkg::DIM_WIDTH-1:0]   out_sub_reg [lits_pkg::NUM_DIMS];
    logic                             out_ok_reg;
    logic                             done_reg;
    logic [lits_pkg::DIM_WIDTH-1:0]   divisor;
    logic [lits_pkg::DIM_WIDTH:0]     shifted;
    logic                             q_bit;
    logic [lits_pkg::DIM_WIDTH-1:0]   rem_step;
    logic                             ok;

    // One restoring division step.
    always_comb
    begin
        divisor = dim_size[cmd.dim_sel];
        shifted = {rem_reg, quot_reg[lits_pkg::INDEX_WIDTH-1]};
        q_bit   = (shifted >= {1'b0, divisor});
        if (q_bit)
            rem_step = lits_pkg::DIM_WIDTH'(shifted - {1'b0, divisor});
        else
            rem_step = shifted[lits_pkg::DIM_WIDTH-1:0];
    end

    // In range exactly when no used size is zero and nothing is left after the last division.
    assign ok = !status.zero_used && (quot_reg == '0);

    // Divider and subscript registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            quot_reg <= flat_index;
            rem_reg  <= '0;
            for (int k = 0; k < lits_pkg::NUM_DIMS; k++)
            begin
                sub_reg[k] <= '0;
            end
        end
        else if (cmd.step)
        begin
            quot_reg <= {quot_reg[lits_pkg::INDEX_WIDTH-2:0], q_bit};
            rem_reg  <= rem_step;
        end
        else if (cmd.store)
        begin
            sub_reg[cmd.dim_sel] <= rem_reg;
            rem_reg              <= '0;
        end
    end

    // Result registers.
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_ok_reg <= ok;
            for (int k = 0; k < lits_pkg::NUM_DIMS; k++)
            begin
                out_sub_reg[k] <= ok ? sub_reg[k] : '0;
            end
        end
    end

    // Result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cmd.finish;
    end

    assign done      = done_reg;
    assign in_range  = out_ok_reg;
    assign subscript = out_sub_reg;

endmodule

// ===== rtl/linear_index_to_subscripts.sv =====
// Top level of the linear index to subscripts converter.
// Instantiates lits_regs, lits_ctrl and lits_dp; depends on lits_pkg.
//
// Usage:
//   Command channel: drive flat_index and pulse start; the transaction is
//   taken at a clock edge where start is high and busy is low. busy stays
//   high while the item is converted.
//   Result: done is high for exactly one cycle with in_range and
//   subscript_0..subscript_3 valid; the receiver cannot stall it and must
//   take it in that cycle. Rejected indexes give in_range low and zero
//   subscripts; unused dimensions give zero subscripts.
//   Sequence: with n used dimensions (n clamped to 4) and no zero size,
//   each runs a 32-step shift-subtract division, one quotient bit per
//   cycle, then a store state writes its remainder; the done state then
//   follows. With n = 0 or a zero size, idle leads straight to the done
//   state. A new item can be accepted in the cycle where done is shown.
//   Configuration: cfg_valid/cfg_ready write channel, cfg_ready always
//   high; cfg_index 0 is num_dims, 1..4 are dim_size_0..3, others ignored.
//   Write only while idle.
//   Reset: rst_n low clears the controller, returns num_dims to 1 and
//   every size to 1; no result is pending afterwards.
module linear_index_to_subscripts (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [lits_pkg::INDEX_WIDTH-1:0]    flat_index,
    output logic                                done,
    output logic                                in_range,
    output logic [lits_pkg::DIM_WIDTH-1:0]      subscript_0,
    output logic [lits_pkg::DIM_WIDTH-1:0]      subscript_1,
    output logic [lits_pkg::DIM_WIDTH-1:0]      subscript_2,
    output logic [lits_pkg::DIM_WIDTH-1:0]      subscript_3,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lits_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
    input  logic [lits_pkg::DIM_WIDTH-1:0]      cfg_data
);

    logic [lits_pkg::DIM_WIDTH-1:0] dim_size [lits_pkg::NUM_DIMS];
    logic [lits_pkg::DIM_WIDTH-1:0] subscript [lits_pkg::NUM_DIMS];
    lits_pkg::cfg_status_t          status;
    lits_pkg::ctrl_cmd_t            cmd;

    // Writes are always taken.
    assign cfg_ready = 1'b1;

    lits_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .dim_size  (dim_size),
        .status    (status)
    );

    lits_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    lits_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .flat_index (flat_index),
        .dim_size   (dim_size),
        .done       (done),
        .in_range   (in_range),
        .subscript  (subscript)
    );

    assign subscript_0 = subscript[0];
    assign subscript_1 = subscript[1];
    assign subscript_2 = subscript[2];
    assign subscript_3 = subscript[3];

endmodule

// ===== rtl/lits_checker.sv =====
// Port-level checker for linear_index_to_subscripts, attached by bind.
// Depends on lits_pkg.
module lits_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                start,
    input logic                                busy,
    input logic                                done,
    input logic                                in_range,
    input logic [lits_pkg::DIM_WIDTH-1:0]      subscript_0,
    input logic [lits_pkg::DIM_WIDTH-1:0]      subscript_1,
    input logic [lits_pkg::DIM_WIDTH-1:0]      subscript_2,
    input logic [lits_pkg::DIM_WIDTH-1:0]      subscript_3
);

    // An accepted transaction makes the block busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

    // A result follows a busy period and is shown while idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy)))
    else $error("result strobe outside the end of a conversion");

    // The result strobe lasts a single cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
    else $error("result strobe longer than one cycle");

    // A rejected index carries zero subscripts.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !in_range) |-> ((subscript_0 == '0) && (subscript_1 == '0)
                                 && (subscript_2 == '0) && (subscript_3 == '0)))
    else $error("rejected index with nonzero subscripts");

endmodule

bind linear_index_to_subscripts lits_checker u_lits_checker (.*);
